### sv/utf8dv_pkg.sv
// Shared types and constants for the UTF-8 stream decoder and validator.
package utf8dv_pkg;

  localparam int unsigned CpW = 21;

  // decoder modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CONT = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;

  localparam logic [7:0] ByteAsciiLim = 8'h80;
  localparam logic [7:0] ByteContLim  = 8'hC0;
  localparam logic [7:0] ByteLeadMin  = 8'hC2;
  localparam logic [7:0] ByteLead3    = 8'hE0;
  localparam logic [7:0] ByteLead4    = 8'hF0;
  localparam logic [7:0] ByteLeadLim  = 8'hF5;

  localparam logic [CpW-1:0] SurrLo  = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi  = 21'h00DFFF;
  localparam logic [CpW-1:0] Lim2    = 21'h000800;  // 1 << (5 + 6)
  localparam logic [CpW-1:0] Lim3    = 21'h010000;  // 1 << (4 + 6 + 6)
  localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
    logic           last;
  } result_t;

endpackage

### sv/utf8_stream_decoder_validator.sv
// UTF-8 byte stream decoder and validator with a four-entry result queue.
// Each result is registered in the queue and presented in order behind any older results.
// Throughput: one byte per cycle while in_stall_o is low; a byte that yields two results (bad
// continuation re-handled as a lead) needs two output beats from the queue.
// in_stall_o rises while fewer than two queue slots are free.
// Reset clears the decode state and empties the result queue.
module utf8_stream_decoder_validator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_buffer_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [utf8dv_pkg::CpW-1:0]   code_point_o,
  output logic                         error_o,
  output logic                         last_of_run_o
);
  import utf8dv_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);

  logic [1:0]     mode_q, mode_d;
  logic [1:0]     rem_q, rem_d;
  logic [2:0]     len_q, len_d;
  logic [CpW-1:0] acc_q, acc_d;

  result_t        q_mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q, count_d;

  logic in_acc, out_acc;
  logic [1:0] n_res;
  result_t res0, res1;

  // lead byte handling
  logic           ld_emit, ld_err;
  logic [CpW-1:0] ld_cp;
  logic [1:0]     ld_mode;
  logic           ld_set;
  logic [2:0]     ld_len;
  logic [CpW-1:0] ld_acc;

  logic           is_cont, is_start;
  logic [CpW-1:0] cont_acc;
  logic [1:0]     cont_rem;

  function automatic logic value_ok(input logic [CpW-1:0] v, input logic [2:0] len);
    logic ok;
    if (v >= SurrLo && v <= SurrHi) ok = 1'b0;
    else if (v < Lim2) ok = (len == 3'd2);
    else if (v < Lim3) ok = (len == 3'd3);
    else ok = (len == 3'd4) && (v <= CpMax);
    return ok;
  endfunction

  assign in_stall_o  = count_q > (PtrW+1)'(QDepth - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign code_point_o  = q_mem[rd_ptr_q].cp;
  assign error_o       = q_mem[rd_ptr_q].err;
  assign last_of_run_o = q_mem[rd_ptr_q].last;

  assign is_cont  = data_byte_i >= ByteAsciiLim && data_byte_i < ByteContLim;
  assign is_start = data_byte_i <= ByteAsciiLim ||
                    (data_byte_i >= ByteLeadMin && data_byte_i < ByteLeadLim);
  assign cont_acc = {acc_q[CpW-7:0], data_byte_i[5:0]};
  assign cont_rem = rem_q - 2'd1;

  always_comb begin
    ld_emit = 1'b1;
    ld_err  = 1'b1;
    ld_cp   = '0;
    ld_set  = 1'b0;
    ld_len  = 3'd2;
    ld_acc  = '0;
    ld_mode = MODE_IDLE;
    if (data_byte_i < ByteAsciiLim) begin
      ld_err = 1'b0;
      ld_cp  = {{(CpW-8){1'b0}}, data_byte_i};
    end else if (data_byte_i >= ByteLeadMin && data_byte_i < ByteLeadLim) begin
      ld_set = 1'b1;
      if (data_byte_i < ByteLead3)      ld_len = 3'd2;
      else if (data_byte_i < ByteLead4) ld_len = 3'd3;
      else                              ld_len = 3'd4;
      ld_acc  = {{(CpW-8){1'b0}}, data_byte_i & (8'h7F >> ld_len)};
      ld_emit = end_of_buffer_i;
      ld_mode = end_of_buffer_i ? MODE_IDLE : MODE_CONT;
    end else begin
      ld_mode = end_of_buffer_i ? MODE_IDLE : MODE_SKIP;
    end
  end

  always_comb begin
    mode_d = mode_q;
    rem_d  = rem_q;
    len_d  = len_q;
    acc_d  = acc_q;
    n_res  = 2'd0;
    res0   = '{cp: '0, err: 1'b1, last: 1'b1};
    res1   = '{cp: '0, err: 1'b1, last: 1'b1};
    if (in_acc) begin
      if (mode_q == MODE_CONT && is_cont) begin
        acc_d = cont_acc;
        rem_d = cont_rem;
        if (cont_rem == 2'd0) begin
          n_res  = 2'd1;
          mode_d = MODE_IDLE;
          if (value_ok(cont_acc, len_q)) begin
            res0.cp  = cont_acc;
            res0.err = 1'b0;
          end
        end else if (end_of_buffer_i) begin
          n_res  = 2'd1;
          mode_d = MODE_IDLE;
        end
      end else if (mode_q == MODE_SKIP && !is_start) begin
        if (end_of_buffer_i) mode_d = MODE_IDLE;
      end else begin
        // lead byte; after MODE_CONT this is a bad continuation: flag it, then treat the byte as a lead
        mode_d = ld_mode;
        if (ld_set) begin
          len_d = ld_len;
          rem_d = 2'(ld_len - 3'd1);
          acc_d = ld_acc;
        end
        if (mode_q == MODE_CONT) begin
          res0.last = !ld_emit;
          res1.cp   = ld_cp;
          res1.err  = ld_err;
          n_res     = ld_emit ? 2'd2 : 2'd1;
        end else begin
          res0.cp  = ld_cp;
          res0.err = ld_err;
          n_res    = ld_emit ? 2'd1 : 2'd0;
        end
      end
    end
    count_d = count_q + (PtrW+1)'(n_res) - (PtrW+1)'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      rem_q    <= '0;
      len_q    <= '0;
      acc_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      rem_q    <= rem_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_acc);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) q_mem[wr_ptr_q] <= res0;
    if (n_res == 2'd2) q_mem[wr_ptr_q + PtrW'(1)] <= res1;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(QDepth))
    else $error("result queue overflow");

  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> code_point_o == '0)
    else $error("error result carries a code point");

  a_eob_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_buffer_i |=> mode_q == MODE_IDLE)
    else $error("decoder not idle after end of buffer");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("unused decode mode reached");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the UTF-8 stream decoder and validator.
module tb;
  import utf8dv_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned BytesPerPhase = 570;

  typedef struct packed {
    logic [7:0]     b;
    logic           eob;
    logic           pred;  // 1: take the decoder model's results
    logic [1:0]     n;
    logic [CpW-1:0] cp0;
    logic           e0;
    logic [CpW-1:0] cp1;
    logic           e1;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                end_of_buffer_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CpW-1:0]      code_point_o;
  logic                error_o;
  logic                last_of_run_o;

  // decoder model state
  logic [1:0]          dec_mode;
  logic [1:0]          cont_left;
  logic [2:0]          seq_len;
  logic [CpW-1:0]      acc_cp;

  result_t             step_res[$];
  result_t             cp_pending_q[$];
  int unsigned         tx_idle;
  int unsigned         rx_idle;
  int unsigned         bytes_sent;
  int unsigned         cycle_cnt;
  int unsigned         fails;

  dir_row_t dir_tab [25] = '{
    '{8'h00, 1'b0, 1'b0, 2'd1, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h7F, 1'b0, 1'b0, 2'd1, 21'h7F,     1'b0, 21'h0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hC0, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h41, 1'b0, 1'b0, 2'd1, 21'h41,     1'b0, 21'h0,  1'b0},
    '{8'hC1, 1'b0, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hF5, 1'b0, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd1, 21'h80,     1'b0, 21'h0,  1'b0},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h41, 1'b0, 1'b0, 2'd2, 21'h0,      1'b1, 21'h41, 1'b0},
    '{8'hED, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hA0, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'hF4, 1'b0, 1'b1, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h8F, 1'b0, 1'b1, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hBF, 1'b0, 1'b1, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hBF, 1'b0, 1'b1, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'h82, 1'b1, 1'b0, 2'd1, 21'h0,      1'b1, 21'h0,  1'b0},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 21'h0,      1'b0, 21'h0,  1'b0},
    '{8'hC2, 1'b1, 1'b0, 2'd2, 21'h0,      1'b1, 21'h0,  1'b1}
  };

  utf8_stream_decoder_validator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_point_o    (code_point_o),
    .error_o         (error_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_res(input logic [CpW-1:0] cp, input logic err);
    result_t r;
    r.cp   = err ? '0 : cp;
    r.err  = err;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic logic start_byte(input logic [7:0] b);
    return b <= ByteAsciiLim || (b >= ByteLeadMin && b < ByteLeadLim);
  endfunction

  function automatic logic cp_legal(input logic [CpW-1:0] v, input logic [2:0] len);
    if (v >= SurrLo && v <= SurrHi) return 1'b0;
    if (v < Lim2) return len == 3'd2;
    if (v < Lim3) return len == 3'd3;
    return len == 3'd4 && v <= CpMax;
  endfunction

  function automatic void open_lead(input logic [7:0] b, input logic eob);
    logic [2:0] len;
    if (b < ByteAsciiLim) begin
      add_res(CpW'(b), 1'b0);
      dec_mode = MODE_IDLE;
    end else if (b >= ByteLeadMin && b < ByteLeadLim) begin
      len       = (b < ByteLead3) ? 3'd2 : (b < ByteLead4) ? 3'd3 : 3'd4;
      seq_len   = len;
      cont_left = 2'(len - 3'd1);
      acc_cp    = CpW'(b & (8'h7F >> len));
      if (eob) begin
        add_res('0, 1'b1);
        dec_mode = MODE_IDLE;
      end else begin
        dec_mode = MODE_CONT;
      end
    end else begin
      add_res('0, 1'b1);
      dec_mode = eob ? MODE_IDLE : MODE_SKIP;
    end
  endfunction

  // Work out the results of one byte and advance the decoder state.
  function automatic void utf8_decode_step(input logic [7:0] b, input logic eob);
    step_res.delete();
    if (dec_mode == MODE_CONT) begin
      if (b >= ByteAsciiLim && b < ByteContLim) begin
        acc_cp    = {acc_cp[CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          if (cp_legal(acc_cp, seq_len)) add_res(acc_cp, 1'b0);
          else add_res('0, 1'b1);
          dec_mode = MODE_IDLE;
        end else if (eob) begin
          add_res('0, 1'b1);
          dec_mode = MODE_IDLE;
        end
      end else begin
        // bad continuation: flag it, then treat the byte as a fresh lead
        add_res('0, 1'b1);
        dec_mode = MODE_IDLE;
        open_lead(b, eob);
      end
    end else if (dec_mode == MODE_SKIP) begin
      if (start_byte(b)) open_lead(b, eob);
      else if (eob) dec_mode = MODE_IDLE;
    end else begin
      open_lead(b, eob);
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob, input logic use_model);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!(dec_mode == MODE_SKIP && !start_byte(b))) bytes_sent++;
    utf8_decode_step(b, eob);
    if (use_model)
      foreach (step_res[i]) cp_pending_q.insert(cp_pending_q.size(), step_res[i]);
  endtask

  // One buffer of mostly well-formed characters, with some broken ones and noise.
  task automatic send_buffer();
    logic [7:0]     bytes_q[$];
    logic [CpW-1:0] cp;
    int unsigned    kind;
    int unsigned    len;
    int unsigned    pos;
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(99);
      len  = $urandom_range(2, 4);
      case (len)
        2:       cp = CpW'($urandom_range('h80, 'h7FF));
        3:       cp = CpW'($urandom_range('h800, 'hFFFF));
        default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (kind < 30) begin
        bytes_q.insert(bytes_q.size(), 8'($urandom_range(127)));
      end else if (kind < 95) begin
        if (kind >= 77 && kind < 81) begin
          cp = CpW'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
        end else if (kind >= 81 && kind < 84) begin
          len = 4;
          cp  = CpW'($urandom_range('h110000, 'h1FFFFF));
        end
        pos = bytes_q.size();
        case (len)
          2: bytes_q.insert(bytes_q.size(), {3'b110, cp[10:6]});
          3: begin
            bytes_q.insert(bytes_q.size(), {4'b1110, cp[15:12]});
            bytes_q.insert(bytes_q.size(), {2'b10, cp[11:6]});
          end
          default: begin
            bytes_q.insert(bytes_q.size(), {5'b11110, cp[20:18]});
            bytes_q.insert(bytes_q.size(), {2'b10, cp[17:12]});
            bytes_q.insert(bytes_q.size(), {2'b10, cp[11:6]});
          end
        endcase
        bytes_q.insert(bytes_q.size(), {2'b10, cp[5:0]});
        if (kind >= 84 && kind < 90) begin
          // cut the sequence short
          repeat ($urandom_range(1, len - 1)) void'(bytes_q.pop_back());
        end else if (kind >= 90) begin
          bytes_q[pos + $urandom_range(1, len - 1)] = 8'($urandom);
        end
      end else begin
        bytes_q.insert(bytes_q.size(), 8'($urandom_range(255)));
      end
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b1);
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < rx_idle);

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Compare each output beat with the oldest expected result.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cp_pending_q.size() == 0) begin
        $display("%0t: unexpected result cp %h err %b last %b", $time,
                 code_point_o, error_o, last_of_run_o);
        fails++;
      end else begin
        want = cp_pending_q.pop_front();
        if (code_point_o !== want.cp) begin
          $display("%0t: code_point expected %h got %h", $time, want.cp, code_point_o);
          fails++;
        end
        if (error_o !== want.err) begin
          $display("%0t: error expected %b got %b", $time, want.err, error_o);
          fails++;
        end
        if (last_of_run_o !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run_o);
          fails++;
        end
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= 8'h00;
    end_of_buffer_i <= 1'b0;
    out_stall_i     <= 1'b0;
    dec_mode   = MODE_IDLE;
    cont_left  = 2'd0;
    seq_len    = 3'd0;
    acc_cp     = '0;
    bytes_sent = 0;
    cycle_cnt  = 0;
    fails      = 0;
    tx_idle    = 6;
    rx_idle    = 87;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 6 : (ph == 1) ? 87 : 0;
      rx_idle = (ph == 0) ? 87 : (ph == 1) ? 6 : 0;
      if (ph == 0) begin
        foreach (dir_tab[i]) begin
          send_byte(dir_tab[i].b, dir_tab[i].eob, dir_tab[i].pred);
          if (!dir_tab[i].pred && dir_tab[i].n != 2'd0)
            cp_pending_q.insert(cp_pending_q.size(),
                                result_t'{dir_tab[i].cp0, dir_tab[i].e0,
                                          dir_tab[i].n == 2'd1});
          if (!dir_tab[i].pred && dir_tab[i].n == 2'd2)
            cp_pending_q.insert(cp_pending_q.size(),
                                result_t'{dir_tab[i].cp1, dir_tab[i].e1, 1'b1});
        end
      end
      while (bytes_sent < BytesPerPhase * (ph + 1)) send_buffer();
      // hold off until every pending result has come back
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (cp_pending_q.size() != 0);
    end

    repeat (10) @(posedge clk_i);
    if (fails == 0 && cp_pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
sv/utf8dv_pkg.sv
sv/utf8_stream_decoder_validator.sv
tb/sv/tb.sv
